### hdl/hcbp_pkg.sv
// shared constants and types for the huffman code bit packer
package hcbp_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int SYM_W        = 8;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int MAX_CODE_LEN = 32;
    localparam int BYTE_W       = 8;
    localparam int PEND_W       = 3;
    localparam int Q_DEPTH      = 4;
    localparam int Q_W          = 3;
    localparam int WIN_W        = CODE_W + BYTE_W;
    localparam int SUM_W        = 7;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_ENCODE = 2'd1,
        KIND_FINISH = 2'd2
    } t_kind;

endpackage

### hdl/hcbp_sym_if.sv
// input word channel: load, encode and finish commands
interface hcbp_sym_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   kind;
    logic [hcbp_pkg::SYM_W-1:0]   symbol;
    logic [hcbp_pkg::CODE_W-1:0]  code_bits;
    logic [hcbp_pkg::LEN_W-1:0]   code_length;

    modport source (output valid, kind, symbol, code_bits, code_length, input ready);
    modport sink   (input valid, kind, symbol, code_bits, code_length, output ready);
endinterface

### hdl/hcbp_res_if.sv
// result word channel: packed bytes, pad counts and error words
interface hcbp_res_if;
    logic                         valid;
    logic                         ready;
    logic [hcbp_pkg::BYTE_W-1:0]  out_byte;
    logic                         last;
    logic                         error;

    modport source (output valid, out_byte, last, error, input ready);
    modport sink   (input valid, out_byte, last, error, output ready);
endinterface

### hdl/huffman_code_bit_packer_unit.sv
// huffman code bit packer: codebook memory, bit accumulator and output byte queue
// an accepted word is registered in the input stage, then fills the output queue
// throughput: one input word per cycle while each word gives at most one result
// and the output takes it; a word's n results (up to 4 per symbol) hold the queue
// until all leave; reset: codebook valid bits, accumulator, pending count and queue
// clear together; no clearing pass, input is taken right after reset
module huffman_code_bit_packer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hcbp_sym_if.sink   i_sym,
    hcbp_res_if.source o_res
);

    // codebook
    logic [hcbp_pkg::CODE_W-1:0]       r_code_mem [hcbp_pkg::SYMBOL_COUNT];
    logic [hcbp_pkg::LEN_W-1:0]        r_len_mem  [hcbp_pkg::SYMBOL_COUNT];
    logic [hcbp_pkg::SYMBOL_COUNT-1:0] r_vld;
    logic [hcbp_pkg::CODE_W-1:0]       r_rd_code;
    logic [hcbp_pkg::LEN_W-1:0]        r_rd_len;

    // input stage
    logic       r_s1_valid;
    logic [1:0] r_s1_kind;
    logic       r_s1_hit;

    // accumulator, left aligned
    logic [hcbp_pkg::BYTE_W-1:0]   r_acc, n_acc;
    logic [hcbp_pkg::PEND_W-1:0]   r_pend, n_pend;

    // output queue, head at index 0
    logic [hcbp_pkg::Q_DEPTH-1:0][hcbp_pkg::BYTE_W-1:0] r_q_byte, n_q_byte;
    logic [hcbp_pkg::Q_W-1:0]                           r_q_left, n_q_left;
    logic                                               r_q_err, n_q_err;

    logic                            w_in_acc;
    logic                            w_out_fire;
    logic                            w_q_free;
    logic                            w_fire;
    logic                            w_load;
    logic [hcbp_pkg::LEN_W-1:0]      w_len_clamp;
    logic [hcbp_pkg::CODE_W-1:0]     w_code_al;
    logic [hcbp_pkg::WIN_W-1:0]      w_win;
    logic [hcbp_pkg::WIN_W-1:0]      w_win_sh;
    logic [hcbp_pkg::SUM_W-1:0]      w_sum;
    logic [hcbp_pkg::Q_W-1:0]        w_nbytes;
    logic [hcbp_pkg::BYTE_W-1:0]     w_rest;

    assign w_in_acc   = i_sym.valid && i_sym.ready;
    assign w_out_fire = o_res.valid && o_res.ready;
    assign w_q_free   = (r_q_left == '0) || ((r_q_left == hcbp_pkg::Q_W'(1)) && w_out_fire);
    assign w_fire     = r_s1_valid && w_q_free;
    assign i_sym.ready = !r_s1_valid || w_q_free;
    assign w_load     = w_in_acc && (i_sym.kind == hcbp_pkg::KIND_LOAD);

    assign w_len_clamp = (i_sym.code_length > hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN)) ?
                         hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN) : i_sym.code_length;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_code_mem[i_sym.symbol] <= i_sym.code_bits;
            r_len_mem[i_sym.symbol]  <= w_len_clamp;
        end
        if (w_in_acc) begin
            r_rd_code <= r_code_mem[i_sym.symbol];
            r_rd_len  <= r_len_mem[i_sym.symbol];
            r_s1_kind <= i_sym.kind;
            r_s1_hit  <= r_vld[i_sym.symbol];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_vld[i_sym.symbol] <= 1'b1;
            end
            if (i_sym.ready) begin
                r_s1_valid <= i_sym.valid;
            end
        end
    end

    // code left aligned, then placed right after the pending bits
    assign w_code_al = r_rd_code << (hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W) - r_rd_len);
    assign w_win     = {r_acc, hcbp_pkg::CODE_W'(0)} |
                       ({w_code_al, hcbp_pkg::BYTE_W'(0)} >> r_pend);
    assign w_sum     = hcbp_pkg::SUM_W'(r_pend) + hcbp_pkg::SUM_W'(r_rd_len);
    assign w_nbytes  = hcbp_pkg::Q_W'(w_sum >> 3);
    assign w_win_sh  = w_win << {w_nbytes, 3'b000};
    assign w_rest    = w_win_sh[hcbp_pkg::WIN_W-1 -: hcbp_pkg::BYTE_W];

    always_comb begin
        n_acc    = r_acc;
        n_pend   = r_pend;
        n_q_byte = r_q_byte;
        n_q_left = r_q_left;
        n_q_err  = r_q_err;
        if (w_out_fire) begin
            for (int k = 0; k < hcbp_pkg::Q_DEPTH - 1; k++) begin
                n_q_byte[k] = r_q_byte[k+1];
            end
            n_q_left = r_q_left - hcbp_pkg::Q_W'(1);
        end
        if (w_fire) begin
            case (hcbp_pkg::t_kind'(r_s1_kind))
                hcbp_pkg::KIND_ENCODE: begin
                    if (!r_s1_hit || (r_rd_len == '0)) begin
                        n_q_byte[0] = '0;
                        n_q_left    = hcbp_pkg::Q_W'(1);
                        n_q_err     = 1'b1;
                    end else begin
                        for (int k = 0; k < hcbp_pkg::Q_DEPTH; k++) begin
                            n_q_byte[k] = w_win[hcbp_pkg::WIN_W-1-hcbp_pkg::BYTE_W*k -:
                                                hcbp_pkg::BYTE_W];
                        end
                        n_q_left = w_nbytes;
                        n_q_err  = 1'b0;
                        n_acc    = w_rest;
                        n_pend   = w_sum[hcbp_pkg::PEND_W-1:0];
                    end
                end
                hcbp_pkg::KIND_FINISH: begin
                    if (r_pend != '0) begin
                        n_q_byte[0] = r_acc;
                        n_q_byte[1] = hcbp_pkg::BYTE_W'(hcbp_pkg::BYTE_W) -
                                      hcbp_pkg::BYTE_W'(r_pend);
                        n_q_left    = hcbp_pkg::Q_W'(2);
                    end else begin
                        n_q_byte[0] = '0;
                        n_q_left    = hcbp_pkg::Q_W'(1);
                    end
                    n_q_err = 1'b0;
                    n_acc   = '0;
                    n_pend  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_byte <= n_q_byte;
        r_q_err  <= n_q_err;
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_pend   <= '0;
            r_q_left <= '0;
        end else begin
            r_acc    <= n_acc;
            r_pend   <= n_pend;
            r_q_left <= n_q_left;
        end
    end

    assign o_res.valid    = r_q_left != '0;
    assign o_res.out_byte = r_q_byte[0];
    assign o_res.last     = r_q_left == hcbp_pkg::Q_W'(1);
    assign o_res.error    = r_q_err;

    // queue never holds more than one symbol's bytes
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_left <= hcbp_pkg::Q_W'(hcbp_pkg::Q_DEPTH))
        else $error("output queue overfilled");

    // bits below the pending ones stay zero
    a_acc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc & (hcbp_pkg::BYTE_W'('1) >> r_pend)) == '0)
        else $error("accumulator holds stray bits");

    // an error word is the sole, zero result of its symbol
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.error |-> o_res.last && (o_res.out_byte == '0))
        else $error("bad error word");

    // a word stays in the stage until the queue can take its results
    a_stage_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_q_free |=> r_s1_valid && $stable(r_s1_kind))
        else $error("stage word lost while queue busy");

endmodule

### tb/huffman_code_bit_packer_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the huffman code bit packer: command stream against a packer model
module huffman_code_bit_packer_unit_tb;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         RANDOM_WORDS = 430;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         HOLD_CYCLES  = 250;
    localparam int         POOL_SIZE    = 16;
    localparam int         EXP_DEPTH    = 4096;

    typedef struct packed {
        logic [hcbp_pkg::BYTE_W-1:0] data;
        logic                        last;
        logic                        err;
    } t_packed_word;

    class packer_scoreboard;
        logic [hcbp_pkg::CODE_W-1:0] code_mem [hcbp_pkg::SYMBOL_COUNT];
        logic [hcbp_pkg::LEN_W-1:0]  len_mem  [hcbp_pkg::SYMBOL_COUNT];
        logic [hcbp_pkg::BYTE_W-1:0] acc;
        int                          pend;
        // ring of result words still due, oldest at exp_head
        t_packed_word                exp_ring [EXP_DEPTH];
        int                          exp_head;
        int                          exp_tail;
        int                          exp_count;
        int                          fail_count;
        int                          words_noted;
        int                          words_checked;
        int                          error_words;

        function new();
            foreach (code_mem[i]) begin
                code_mem[i] = '0;
                len_mem[i]  = '0;
            end
            acc           = '0;
            pend          = 0;
            exp_head      = 0;
            exp_tail      = 0;
            exp_count     = 0;
            fail_count    = 0;
            words_noted   = 0;
            words_checked = 0;
            error_words   = 0;
        endfunction

        function void expect_word(t_packed_word w);
            exp_ring[exp_tail] = w;
            exp_tail = (exp_tail + 1) % EXP_DEPTH;
            exp_count++;
        endfunction

        // works out the result words one accepted command causes
        function void predict_bytes(logic [1:0] kind, logic [hcbp_pkg::SYM_W-1:0] sym,
                                    logic [hcbp_pkg::CODE_W-1:0] bits,
                                    logic [hcbp_pkg::LEN_W-1:0] len);
            t_packed_word w;
            int           k;
            int           n_new;
            n_new = 0;
            words_noted++;
            case (kind)
                hcbp_pkg::KIND_LOAD: begin
                    code_mem[sym] = bits;
                    len_mem[sym]  = (len > hcbp_pkg::MAX_CODE_LEN) ?
                                    hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN) : len;
                end
                hcbp_pkg::KIND_ENCODE: begin
                    if (len_mem[sym] == '0) begin
                        // absent entry: accumulator stays as it is
                        w = '{data: '0, last: 1'b1, err: 1'b1};
                        expect_word(w);
                    end else begin
                        for (k = int'(len_mem[sym]) - 1; k >= 0; k--) begin
                            acc = {acc[hcbp_pkg::BYTE_W-2:0], code_mem[sym][k]};
                            pend++;
                            if (pend == hcbp_pkg::BYTE_W) begin
                                w = '{data: acc, last: 1'b0, err: 1'b0};
                                expect_word(w);
                                n_new++;
                                acc  = '0;
                                pend = 0;
                            end
                        end
                        if (n_new > 0)
                            exp_ring[(exp_tail + EXP_DEPTH - 1) % EXP_DEPTH].last = 1'b1;
                    end
                end
                hcbp_pkg::KIND_FINISH: begin
                    if (pend != 0) begin
                        w = '{data: hcbp_pkg::BYTE_W'(acc << (hcbp_pkg::BYTE_W - pend)),
                              last: 1'b0, err: 1'b0};
                        expect_word(w);
                        w = '{data: hcbp_pkg::BYTE_W'(hcbp_pkg::BYTE_W - pend),
                              last: 1'b1, err: 1'b0};
                        expect_word(w);
                    end else begin
                        w = '{data: '0, last: 1'b1, err: 1'b0};
                        expect_word(w);
                    end
                    acc  = '0;
                    pend = 0;
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what);
            fail_count++;
            $display("mismatch @%0t: %s", $time, what);
        endtask

        task check_byte(logic [hcbp_pkg::BYTE_W-1:0] data, logic last, logic err);
            t_packed_word want;
            if (exp_count == 0) begin
                report_mismatch($sformatf("unexpected word byte=%02h last=%b err=%b",
                                          data, last, err));
                return;
            end
            want = exp_ring[exp_head];
            exp_head = (exp_head + 1) % EXP_DEPTH;
            exp_count--;
            words_checked++;
            if (want.err)
                error_words++;
            if (data !== want.data)
                report_mismatch($sformatf("word %0d byte %02h, want %02h",
                                          words_checked, data, want.data));
            if (last !== want.last)
                report_mismatch($sformatf("word %0d last %b, want %b",
                                          words_checked, last, want.last));
            if (err !== want.err)
                report_mismatch($sformatf("word %0d error %b, want %b",
                                          words_checked, err, want.err));
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    int unsigned      cycle_count = 0;
    bit               sender_burst = 1'b0;
    packer_scoreboard sb;

    hcbp_sym_if sym_if ();
    hcbp_res_if res_if ();

    huffman_code_bit_packer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sym   (sym_if),
        .o_res   (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due",
                     cycle_count, sb.exp_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // valid stays high across back-to-back words, lowered only for a gap
    task automatic send_word(input logic [1:0] kind, input logic [hcbp_pkg::SYM_W-1:0] sym,
                             input logic [hcbp_pkg::CODE_W-1:0] bits,
                             input logic [hcbp_pkg::LEN_W-1:0] len);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            sym_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sym_if.valid       <= 1'b1;
        sym_if.kind        <= kind;
        sym_if.symbol      <= sym;
        sym_if.code_bits   <= bits;
        sym_if.code_length <= len;
        do @(posedge i_clk); while (sym_if.ready !== 1'b1);
        sb.predict_bytes(kind, sym, bits, len);
    endtask

    initial begin : result_side
        int gap;
        int got;
        got = 0;
        res_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (got == 40 || got == 300)
                gap = HOLD_CYCLES;    // long back-pressure, sender keeps going
            else if (got >= 120 && got < 180)
                gap = 0;
            else
                gap = $urandom_range(0, 3);
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            sb.check_byte(res_if.out_byte, res_if.last, res_if.error);
            got++;
        end
    end

    initial begin : command_side
        logic [hcbp_pkg::SYM_W-1:0]  pool [POOL_SIZE];
        logic [hcbp_pkg::SYM_W-1:0]  sym;
        logic [hcbp_pkg::CODE_W-1:0] bits;
        logic [hcbp_pkg::LEN_W-1:0]  len;
        logic [1:0]                  junk_kind;
        int                          roll;
        int                          pick;
        int                          sent;
        sb = new();
        i_rst_n            <= 1'b0;
        sym_if.valid       <= 1'b0;
        sym_if.kind        <= hcbp_pkg::KIND_LOAD;
        sym_if.symbol      <= '0;
        sym_if.code_bits   <= '0;
        sym_if.code_length <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words
        send_word(hcbp_pkg::KIND_ENCODE, 8'd0,   32'h0000_0000, 6'd0);   // nothing loaded yet
        send_word(hcbp_pkg::KIND_FINISH, 8'd0,   32'h0000_0000, 6'd0);   // empty flush
        send_word(hcbp_pkg::KIND_LOAD,   8'd0,   32'hFFFF_FFFF, 6'd32);
        send_word(hcbp_pkg::KIND_LOAD,   8'd255, 32'h0000_0001, 6'd1);
        send_word(hcbp_pkg::KIND_LOAD,   8'd1,   32'h0000_0000, 6'd63);  // clamps to max
        send_word(hcbp_pkg::KIND_LOAD,   8'd2,   32'h0000_0005, 6'd3);
        send_word(hcbp_pkg::KIND_LOAD,   8'd3,   32'hFFFF_FFE5, 6'd5);   // high bits ignored
        send_word(hcbp_pkg::KIND_ENCODE, 8'd0,   32'h0000_0000, 6'd0);
        send_word(hcbp_pkg::KIND_ENCODE, 8'd255, 32'h0000_0000, 6'd0);
        send_word(hcbp_pkg::KIND_ENCODE, 8'd2,   32'h0000_0000, 6'd0);
        send_word(hcbp_pkg::KIND_FINISH, 8'd0,   32'h0000_0000, 6'd0);
        send_word(hcbp_pkg::KIND_ENCODE, 8'd1,   32'h0000_0000, 6'd0);
        send_word(hcbp_pkg::KIND_ENCODE, 8'd255, 32'h0000_0000, 6'd0);
        send_word(hcbp_pkg::KIND_ENCODE, 8'd0,   32'h0000_0000, 6'd0);
        send_word(hcbp_pkg::KIND_ENCODE, 8'd3,   32'h0000_0000, 6'd0);
        send_word(hcbp_pkg::KIND_ENCODE, 8'd128, 32'h0000_0000, 6'd0);   // absent, bits pending
        send_word(KIND_UNUSED,           8'hA5,  32'hDEAD_BEEF, 6'd17);
        send_word(hcbp_pkg::KIND_FINISH, 8'd0,   32'h0000_0000, 6'd0);
        send_word(hcbp_pkg::KIND_LOAD,   8'd0,   32'h0000_0000, 6'd0);   // entry removed
        send_word(hcbp_pkg::KIND_ENCODE, 8'd0,   32'h0000_0000, 6'd0);
        send_word(hcbp_pkg::KIND_LOAD,   8'd4,   32'h0000_005A, 6'd7);
        send_word(hcbp_pkg::KIND_ENCODE, 8'd4,   32'h0000_0000, 6'd0);
        send_word(hcbp_pkg::KIND_ENCODE, 8'd255, 32'h0000_0000, 6'd0);   // fills one byte
        send_word(hcbp_pkg::KIND_LOAD,   8'd5,   32'h8000_0000, 6'd33);
        send_word(hcbp_pkg::KIND_ENCODE, 8'd5,   32'h0000_0000, 6'd0);
        send_word(hcbp_pkg::KIND_FINISH, 8'd0,   32'h0000_0000, 6'd0);

        // random part: a small pool of loaded symbols keeps most encodes valid
        foreach (pool[i]) begin
            pool[i] = hcbp_pkg::SYM_W'($urandom_range(0, hcbp_pkg::SYMBOL_COUNT - 1));
            bits    = $urandom;
            len     = hcbp_pkg::LEN_W'($urandom_range(1, hcbp_pkg::MAX_CODE_LEN));
            send_word(hcbp_pkg::KIND_LOAD, pool[i], bits, len);
        end
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            sender_burst = ((sent / 60) % 3 == 1);
            roll = $urandom_range(0, 99);
            sym  = pool[$urandom_range(0, POOL_SIZE - 1)];
            bits = $urandom;
            len  = hcbp_pkg::LEN_W'($urandom_range(1, hcbp_pkg::MAX_CODE_LEN));
            if (roll < 3) begin
                junk_kind = KIND_UNUSED;
                send_word(junk_kind, hcbp_pkg::SYM_W'($urandom), bits,
                          hcbp_pkg::LEN_W'($urandom));
            end else if (roll < 13) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    len = '0;
                else if (pick == 1)
                    len = hcbp_pkg::LEN_W'($urandom_range(hcbp_pkg::MAX_CODE_LEN + 1, 63));
                else if (pick < 5)
                    len = hcbp_pkg::LEN_W'($urandom_range(1, 8));
                if ($urandom_range(0, 4) == 0)
                    sym = hcbp_pkg::SYM_W'($urandom_range(0, hcbp_pkg::SYMBOL_COUNT - 1));
                send_word(hcbp_pkg::KIND_LOAD, sym, bits, len);
                sent++;
            end else if (roll < 25) begin
                send_word(hcbp_pkg::KIND_FINISH, sym, bits, len);
                sent++;
            end else begin
                if ($urandom_range(0, 19) == 0)
                    sym = hcbp_pkg::SYM_W'($urandom_range(0, hcbp_pkg::SYMBOL_COUNT - 1));
                send_word(hcbp_pkg::KIND_ENCODE, sym, bits, len);
                sent++;
            end
        end
        sym_if.valid <= 1'b0;

        while (sb.exp_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d command words (loads, encodes, flushes, unused kind)",
                 sb.words_noted);
        $display("checked %0d result words, %0d of them absent-symbol errors",
                 sb.words_checked, sb.error_words);
        if (sb.fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
hdl/hcbp_pkg.sv
hdl/hcbp_sym_if.sv
hdl/hcbp_res_if.sv
hdl/huffman_code_bit_packer_unit.sv
tb/huffman_code_bit_packer_unit_tb.sv
